[hw/rtl/acfcv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acfcv_pkg
// Shared types and constants of the frame checksum validator.
// ---------------------------------------------------------------------------
package acfcv_pkg;

   localparam int SHORT_LENGTH         = 20;
   localparam int LONG_LENGTH          = 33;
   localparam int SHORT_CHECK_POSITION = 18;
   localparam int LONG_CHECK_POSITION  = 32;

   localparam int POS_W = 6;
   localparam int SUM_W = 16;

   localparam logic [POS_W-1:0] POS_MAX        = '1;
   localparam logic [POS_W-1:0] SHORT_LAST     = POS_W'(SHORT_LENGTH - 1);
   localparam logic [POS_W-1:0] LONG_LAST      = POS_W'(LONG_LENGTH - 1);
   localparam logic [POS_W-1:0] SHORT_CHK_HI   = POS_W'(SHORT_CHECK_POSITION);
   localparam logic [POS_W-1:0] SHORT_CHK_LO   = POS_W'(SHORT_CHECK_POSITION + 1);
   localparam logic [POS_W-1:0] LONG_CHK       = POS_W'(LONG_CHECK_POSITION);
   localparam logic [POS_W-1:0] SIG_LAST       = POS_W'(2);

   // signature bytes; bit 0 of the first byte is don't-care
   localparam logic [7:0] SIG0_MASK  = 8'hfe;
   localparam logic [7:0] SIG0_VALUE = 8'h6c;
   localparam logic [7:0] SIG1_VALUE = 8'h80;
   localparam logic [7:0] SIG2_VALUE = 8'h04;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_SIG   = 2'd1;
   localparam status_type STATUS_BAD_SHORT = 2'd2;
   localparam status_type STATUS_BAD_LONG  = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0] byte_position;
      logic [SUM_W-1:0] running_sum;
      logic             signature_bad;
      status_type       first_error;
      logic             long_mode;
      logic [7:0]       held_high_checksum;
   } frame_state_type;

endpackage : acfcv_pkg
`default_nettype wire

[hw/rtl/acfcv_channel_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acfcv_req_if / acfcv_rsp_if
// Valid/ready channels carrying frame bytes in and status beats out.
// ---------------------------------------------------------------------------
interface acfcv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   logic       long_frame;

   modport source (output valid, output data_byte, output frame_start,
                   output long_frame, input ready);
   modport sink   (input valid, input data_byte, input frame_start,
                   input long_frame, output ready);
endinterface : acfcv_req_if

interface acfcv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface : acfcv_rsp_if
`default_nettype wire

[hw/rtl/acfcv_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acfcv_step
// Next-state logic for one frame byte: signature check, short and long
// checksum compares, running sum and position update, end-of-frame detect.
// ---------------------------------------------------------------------------
module acfcv_step
   import acfcv_pkg::*;
(
   input  var frame_state_type cur_state,
   input  var logic [7:0]      data_byte,
   input  var logic            frame_start,
   input  var logic            long_frame,
   output frame_state_type     nxt_state,
   output logic                frame_done,
   output status_type          status
);

   frame_state_type  base;
   logic             sig_ok;
   logic [SUM_W-1:0] byte_ext;
   logic [SUM_W-1:0] held_ext;
   logic [POS_W-1:0] last_pos;

   always_comb begin
      // a start beat restarts the frame before this byte is judged
      base = cur_state;
      if (frame_start) begin
         base.byte_position      = '0;
         base.running_sum        = '0;
         base.signature_bad      = 1'b0;
         base.first_error        = STATUS_OK;
         base.held_high_checksum = '0;
         base.long_mode          = long_frame;
      end

      byte_ext = {8'h00, data_byte};
      held_ext = {8'h00, base.held_high_checksum};

      case (base.byte_position)
         '0:      sig_ok = (data_byte & SIG0_MASK) == SIG0_VALUE;
         POS_W'(1): sig_ok = data_byte == SIG1_VALUE;
         default: sig_ok = data_byte == SIG2_VALUE;
      endcase

      nxt_state = base;
      if (base.byte_position <= SIG_LAST && !sig_ok) begin
         nxt_state.signature_bad = 1'b1;
      end

      if (base.byte_position == SHORT_CHK_HI) begin
         nxt_state.held_high_checksum = data_byte;
      end else if (base.byte_position == SHORT_CHK_LO) begin
         if (nxt_state.first_error == STATUS_OK) begin
            if (nxt_state.signature_bad) begin
               nxt_state.first_error = STATUS_BAD_SIG;
            end else if (base.held_high_checksum != base.running_sum[15:8] ||
                         data_byte != base.running_sum[7:0]) begin
               nxt_state.first_error = STATUS_BAD_SHORT;
            end
         end
         nxt_state.running_sum = base.running_sum + held_ext + byte_ext;
      end else if (base.byte_position == LONG_CHK) begin
         if (data_byte != base.running_sum[7:0] &&
             nxt_state.first_error == STATUS_OK) begin
            nxt_state.first_error = STATUS_BAD_LONG;
         end
      end else begin
         nxt_state.running_sum = base.running_sum + byte_ext;
      end

      // position saturates past the frame end
      if (base.byte_position != POS_MAX) begin
         nxt_state.byte_position = base.byte_position + POS_W'(1);
      end

      last_pos   = base.long_mode ? LONG_LAST : SHORT_LAST;
      frame_done = base.byte_position == last_pos;
      status     = nxt_state.first_error;
   end

endmodule : acfcv_step
`default_nettype wire

[hw/rtl/ac_frame_checksum_validator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ac_frame_checksum_validator
// Checks signature and checksums of short and long serial frames.
// ---------------------------------------------------------------------------
// One byte beat is taken every clock cycle while the input is not stalled.
// The byte is judged against the frame state registers by a single
// add-and-compare path and the state is updated at the same edge; on the
// frame's last byte a status beat is loaded into the output register.
// The output register lets the next byte in while a status beat waits, so
// the input stalls only when a status beat is pending and the sink holds
// off. Bytes seen before any frame start belong to a short frame begun at
// reset; bytes past the frame end give no status.
// ---------------------------------------------------------------------------
module ac_frame_checksum_validator
   import acfcv_pkg::*;
(
   input  var logic        clock,
   input  var logic        reset,
   acfcv_req_if.sink       req_bus,
   acfcv_rsp_if.source     rsp_bus
);

   frame_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic            frame_done;
   status_type      status;
   logic            req_beat;

   acfcv_step u_step (
      .cur_state   (state_ff),
      .data_byte   (req_bus.data_byte),
      .frame_start (req_bus.frame_start),
      .long_frame  (req_bus.long_frame),
      .nxt_state   (state_in),
      .frame_done  (frame_done),
      .status      (status)
   );

   assign req_bus.ready  = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat       = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      if (req_beat && frame_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_beat) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
   end

endmodule : ac_frame_checksum_validator
`default_nettype wire
